@@ rtl/lpe_pkg.sv @@
// Shared types, constants and helpers for the line position estimator.
// Used by lpe_lane, lpe_merge and the top level; depends on nothing.
`timescale 1ns / 1ps

package lpe_pkg;

	// Fixed widths of the result and threshold fields
	localparam int POS_W       = 13;
	localparam int NORM_W      = 10;
	localparam int THR_W       = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int HW_CHANNELS = 8;
	localparam int HIST_DEPTH  = 3;

	// Full scale of a normalised channel and of one channel step in position
	localparam logic [NORM_W-1:0] NORM_FULL = NORM_W'(1000);
	localparam int                STEP      = 1000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HI  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_THR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_THR = 3'd5;

	// Reset values of the threshold registers
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);

	// History slot wrap point
	localparam logic [1:0] SLOT_LAST = 2'd2;

	// Top level sequencer
	typedef enum logic [1:0] {
		T_IDLE,
		T_NORM,
		T_MERGE
	} top_state_t;

	// Merge stage sequencer
	typedef enum logic [1:0] {
		M_IDLE,
		M_ACC,
		M_DIV,
		M_DONE
	} merge_state_t;

	// One result item as handed from the merge stage to the output register
	typedef struct packed {
		logic [POS_W-1:0] filtered_position;
		logic [POS_W-1:0] raw_position;
		logic             line_seen;
		logic             on_line;
		logic [POS_W-1:0] binary_position;
	} merge_res_t;

	// Median of three positions
	function automatic logic [POS_W-1:0] median3(
		input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b,
		input logic [POS_W-1:0] c
	);
		logic [POS_W-1:0] lo_ab;
		logic [POS_W-1:0] hi_ab;
		logic [POS_W-1:0] lo_hc;
		lo_ab = (a < b) ? a : b;
		hi_ab = (a > b) ? a : b;
		lo_hc = (hi_ab < c) ? hi_ab : c;
		return (lo_ab > lo_hc) ? lo_ab : lo_hc;
	endfunction

endpackage

@@ rtl/lpe_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Shared by the channel lanes and the merge stage; no package use.
`timescale 1ns / 1ps

module lpe_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             take;
	logic [DEN_W:0]   trial_sub;

	// Shift the next numerator bit into the partial remainder and try the divisor
	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		take      = (trial >= {1'b0, den_q});
		trial_sub = trial - {1'b0, den_q};
	end

	// Control: count the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	// A new division never starts on top of one still running
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	// The done pulse follows the final step of a running division
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	// The step counter is empty once the divider is idle
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> cnt_q == '0)
		else $error("divider stopped with steps left");

endmodule

@@ rtl/lpe_lane.sv @@
// One channel lane: offset removal, scaling and clamped division to 0..1000.
// Depends on lpe_pkg and lpe_div.
`timescale 1ns / 1ps

module lpe_lane #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [SAMPLE_BITS-1:0]        cal_min,
	input  logic [SAMPLE_BITS-1:0]        cal_max,
	output logic                          done,
	output logic [lpe_pkg::NORM_W-1:0]    norm
);

	localparam int NUM_W = SAMPLE_BITS + lpe_pkg::NORM_W;

	logic [SAMPLE_BITS-1:0]     diff;
	logic [SAMPLE_BITS-1:0]     span;
	logic [NUM_W-1:0]           num_s1;
	logic [SAMPLE_BITS-1:0]     den_s1;
	logic                       go_s1;
	logic                       div_done;
	logic [NUM_W-1:0]           div_quo;
	logic                       done_q;
	logic [lpe_pkg::NORM_W-1:0] norm_q;

	// Offset above the minimum (zero at or below it) and the usable span
	always_comb begin
		diff = (sample > cal_min) ? (sample - cal_min) : '0;
		span = (cal_max > cal_min) ? (cal_max - cal_min) : SAMPLE_BITS'(1);
	end

	// Scale the offset to full-scale units and hold the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			num_s1 <= NUM_W'(diff) * NUM_W'(lpe_pkg::NORM_FULL);
			den_s1 <= span;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= start;
		end
	end

	lpe_div #(
		.NUM_W (NUM_W),
		.DEN_W (SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_s1),
		.num    (num_s1),
		.den    (den_s1),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Clamp the quotient to full scale
	always_ff @(posedge clk) begin
		if (div_done) begin
			norm_q <= (div_quo > NUM_W'(lpe_pkg::NORM_FULL)) ?
				lpe_pkg::NORM_FULL : div_quo[lpe_pkg::NORM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_done;
		end
	end

	assign done = done_q;
	assign norm = norm_q;

	// A finished lane never reports above full scale
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> norm_q <= lpe_pkg::NORM_FULL)
		else $error("normalised value above full scale");

	// The divider is started in the cycle after the lane start
	a_go_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> go_s1)
		else $error("lane divider not started");

	// A lane result never coincides with a fresh divider start
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !go_s1)
		else $error("lane done overlaps a fresh start");

endmodule

@@ rtl/lpe_merge.sv @@
// Merge stage: walks the lane results, forms both centroids with serial
// dividers and keeps the median history. Depends on lpe_pkg and lpe_div.
`timescale 1ns / 1ps

module lpe_merge #(
	parameter int CHANNELS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [CHANNELS-1:0][lpe_pkg::NORM_W-1:0] norm,
	input  logic [lpe_pkg::THR_W-1:0]                on_thr,
	input  logic [lpe_pkg::THR_W-1:0]                bin_thr,
	input  logic                                     filter_reset,
	input  logic                                     commit,
	output logic                                     ready,
	output lpe_pkg::merge_res_t                      res
);

	localparam int IDX_W  = $clog2(CHANNELS);
	localparam int SUM_W  = $clog2(1000 * CHANNELS + 1);
	localparam int WT_W   = $clog2(lpe_pkg::STEP * (CHANNELS - 1) + 1);
	localparam int WSUM_W = $clog2(1000 * lpe_pkg::STEP * CHANNELS * (CHANNELS - 1) / 2 + 1);
	localparam int PROD_W = lpe_pkg::NORM_W + WT_W;

	lpe_pkg::merge_state_t m_state_q, m_state_nxt;

	logic [IDX_W-1:0]           idx_q;
	logic [WT_W-1:0]            wt_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           bsum_q;
	logic [WSUM_W-1:0]          wsum_q;
	logic [WSUM_W-1:0]          bwsum_q;
	logic [lpe_pkg::NORM_W-1:0] peak_q;
	logic                       div_go_q;

	logic                       acc_en;
	logic                       idx_last;
	logic [lpe_pkg::NORM_W-1:0] cur;
	logic [PROD_W-1:0]          prod;
	logic                       above_bin;

	logic                       raw_done;
	logic                       bin_done;
	logic [WSUM_W-1:0]          raw_quo;
	logic [WSUM_W-1:0]          bin_quo;

	logic [lpe_pkg::HIST_DEPTH-1:0][lpe_pkg::POS_W-1:0] hist_q;
	logic [1:0]                                         slot_q;
	logic [lpe_pkg::POS_W-1:0]                          held_q;
	logic [lpe_pkg::POS_W-1:0]                          last_raw_q;

	logic [lpe_pkg::HIST_DEPTH-1:0][lpe_pkg::POS_W-1:0] hist_nxt;
	logic [1:0]                                         slot_base;
	logic [1:0]                                         slot_nxt;
	logic [lpe_pkg::POS_W-1:0]                          held_nxt;
	logic [lpe_pkg::POS_W-1:0]                          last_nxt;
	logic                                               seen;

	// Next state
	always_comb begin
		m_state_nxt = m_state_q;
		unique case (m_state_q)
			lpe_pkg::M_IDLE: if (start) begin
				m_state_nxt = lpe_pkg::M_ACC;
			end
			lpe_pkg::M_ACC: if (idx_last) begin
				m_state_nxt = lpe_pkg::M_DIV;
			end
			lpe_pkg::M_DIV: if (raw_done && bin_done) begin
				m_state_nxt = lpe_pkg::M_DONE;
			end
			lpe_pkg::M_DONE: if (commit) begin
				m_state_nxt = lpe_pkg::M_IDLE;
			end
			default: m_state_nxt = lpe_pkg::M_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		acc_en = (m_state_q == lpe_pkg::M_ACC);
		ready  = (m_state_q == lpe_pkg::M_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_state_q <= lpe_pkg::M_IDLE;
			div_go_q  <= 1'b0;
		end else begin
			m_state_q <= m_state_nxt;
			div_go_q  <= acc_en && idx_last;
		end
	end

	// Current lane and its weighted contribution
	always_comb begin
		idx_last  = (idx_q == IDX_W'(CHANNELS - 1));
		cur       = norm[idx_q];
		prod      = PROD_W'(cur) * PROD_W'(wt_q);
		above_bin = (cur > bin_thr);
	end

	// Accumulate one lane per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			idx_q   <= '0;
			wt_q    <= '0;
			sum_q   <= '0;
			bsum_q  <= '0;
			wsum_q  <= '0;
			bwsum_q <= '0;
			peak_q  <= '0;
		end else if (acc_en) begin
			idx_q  <= idx_q + IDX_W'(1);
			wt_q   <= wt_q + WT_W'(lpe_pkg::STEP);
			sum_q  <= sum_q + SUM_W'(cur);
			wsum_q <= wsum_q + WSUM_W'(prod);
			if (cur > peak_q) begin
				peak_q <= cur;
			end
			if (above_bin) begin
				bsum_q  <= bsum_q + SUM_W'(cur);
				bwsum_q <= bwsum_q + WSUM_W'(prod);
			end
		end
	end

	// Weighted centroid over all channels
	lpe_div #(
		.NUM_W (WSUM_W),
		.DEN_W (SUM_W)
	) u_raw_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (wsum_q),
		.den    (sum_q),
		.done   (raw_done),
		.quo    (raw_quo)
	);

	// Centroid over channels above the binary threshold
	lpe_div #(
		.NUM_W (WSUM_W),
		.DEN_W (SUM_W)
	) u_bin_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (bwsum_q),
		.den    (bsum_q),
		.done   (bin_done),
		.quo    (bin_quo)
	);

	// Filter update: optional reload, then history write and median
	always_comb begin
		seen      = (sum_q != '0);
		hist_nxt  = filter_reset ? {lpe_pkg::HIST_DEPTH{last_raw_q}} : hist_q;
		held_nxt  = filter_reset ? last_raw_q : held_q;
		slot_base = (slot_q > lpe_pkg::SLOT_LAST) ? 2'd0 : slot_q;
		slot_nxt  = slot_q;
		last_nxt  = last_raw_q;
		if (seen) begin
			last_nxt            = raw_quo[lpe_pkg::POS_W-1:0];
			hist_nxt[slot_base] = raw_quo[lpe_pkg::POS_W-1:0];
			slot_nxt            = (slot_base == lpe_pkg::SLOT_LAST) ? 2'd0 :
				slot_base + 2'd1;
			held_nxt            = lpe_pkg::median3(hist_nxt[0], hist_nxt[1], hist_nxt[2]);
		end
		res.filtered_position = held_nxt;
		res.raw_position      = last_nxt;
		res.line_seen         = seen;
		res.on_line           = (peak_q > on_thr);
		res.binary_position   = (bsum_q != '0) ? bin_quo[lpe_pkg::POS_W-1:0] : held_nxt;
	end

	// Filter state advances only when the result is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q     <= '0;
			slot_q     <= '0;
			held_q     <= '0;
			last_raw_q <= '0;
		end else if (ready && commit) begin
			hist_q     <= hist_nxt;
			slot_q     <= slot_nxt;
			held_q     <= held_nxt;
			last_raw_q <= last_nxt;
		end
	end

	// History slot stays within the three entries
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= lpe_pkg::SLOT_LAST)
		else $error("history slot out of range");

	// A scan with no line has no peak and no binary channels
	a_empty_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ready && !seen |-> peak_q == '0 && bsum_q == '0)
		else $error("empty scan with nonzero channel");

	// Both dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		raw_done == bin_done)
		else $error("centroid dividers out of step");

	// A start is only given while the stage is idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> m_state_q == lpe_pkg::M_IDLE)
		else $error("merge started while busy");

endmodule

@@ rtl/line_position_estimator.sv @@
// Top level of the line position estimator: ports, configuration registers,
// channel lanes, merge stage and output register. Depends on lpe_pkg,
// lpe_lane and lpe_merge.
//
//  channel | handshake              | carries
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | sample_0..sample_7, filter_reset
//  out     | out_valid / out_stall  | filtered_position, raw_position,
//          |                        | line_seen, on_line, binary_position
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A scan passes from transfer in through the lane scaling, the serial lane
// dividers, the merge accumulation over the channels and the serial centroid
// dividers (weighted-sum width 25 for eight channels) to result ready. One
// scan is in work at a time; a new scan is taken while the previous result
// still waits in the output register. Reset clears the filter history and
// loads the calibration and threshold defaults; no clearing pass follows.
// out_stall only holds the output register; a finished scan waits in the
// merge stage until it is free.
`timescale 1ns / 1ps

module line_position_estimator #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [SAMPLE_BITS-1:0]          sample_0,
	input  logic [SAMPLE_BITS-1:0]          sample_1,
	input  logic [SAMPLE_BITS-1:0]          sample_2,
	input  logic [SAMPLE_BITS-1:0]          sample_3,
	input  logic [SAMPLE_BITS-1:0]          sample_4,
	input  logic [SAMPLE_BITS-1:0]          sample_5,
	input  logic [SAMPLE_BITS-1:0]          sample_6,
	input  logic [SAMPLE_BITS-1:0]          sample_7,
	input  logic                            filter_reset,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lpe_pkg::POS_W-1:0]       filtered_position,
	output logic [lpe_pkg::POS_W-1:0]       raw_position,
	output logic                            line_seen,
	output logic                            on_line,
	output logic [lpe_pkg::POS_W-1:0]       binary_position,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [4*SAMPLE_BITS-1:0]        cfg_data
);

	localparam int PACK_W = 4 * SAMPLE_BITS;
	localparam logic [PACK_W-1:0] MAX_RESET = {4{{(SAMPLE_BITS-1){1'b0}}, 1'b1}};

	lpe_pkg::top_state_t state_q, state_nxt;

	logic [PACK_W-1:0]               min_lo_q;
	logic [PACK_W-1:0]               min_hi_q;
	logic [PACK_W-1:0]               max_lo_q;
	logic [PACK_W-1:0]               max_hi_q;
	logic [lpe_pkg::THR_W-1:0]       on_thr_q;
	logic [lpe_pkg::THR_W-1:0]       bin_thr_q;

	logic [lpe_pkg::HW_CHANNELS-1:0][SAMPLE_BITS-1:0] samp_q;
	logic                            freset_q;
	logic                            start_q;

	logic                            in_xfer;
	logic                            out_xfer;
	logic                            cfg_xfer;
	logic                            merge_start;
	logic                            commit;
	logic                            merge_ready;
	lpe_pkg::merge_res_t             merge_res;
	lpe_pkg::merge_res_t             res_q;
	logic                            out_valid_q;

	logic [CHANNELS-1:0][lpe_pkg::NORM_W-1:0] lane_norm;
	logic [CHANNELS-1:0]                      lane_done;
	logic                                     lanes_done;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;
	assign cfg_xfer = cfg_valid && cfg_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lo_q  <= '0;
			min_hi_q  <= '0;
			max_lo_q  <= MAX_RESET;
			max_hi_q  <= MAX_RESET;
			on_thr_q  <= lpe_pkg::THR_RESET;
			bin_thr_q <= lpe_pkg::THR_RESET;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				lpe_pkg::CFG_MIN_LO:  min_lo_q  <= cfg_data;
				lpe_pkg::CFG_MIN_HI:  min_hi_q  <= cfg_data;
				lpe_pkg::CFG_MAX_LO:  max_lo_q  <= cfg_data;
				lpe_pkg::CFG_MAX_HI:  max_hi_q  <= cfg_data;
				lpe_pkg::CFG_ON_THR:  on_thr_q  <= cfg_data[lpe_pkg::THR_W-1:0];
				lpe_pkg::CFG_BIN_THR: bin_thr_q <= cfg_data[lpe_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the scan on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			samp_q[0] <= sample_0;
			samp_q[1] <= sample_1;
			samp_q[2] <= sample_2;
			samp_q[3] <= sample_3;
			samp_q[4] <= sample_4;
			samp_q[5] <= sample_5;
			samp_q[6] <= sample_6;
			samp_q[7] <= sample_7;
			freset_q  <= filter_reset;
		end
	end

	// Sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lpe_pkg::T_IDLE: if (in_xfer) begin
				state_nxt = lpe_pkg::T_NORM;
			end
			lpe_pkg::T_NORM: if (lanes_done) begin
				state_nxt = lpe_pkg::T_MERGE;
			end
			lpe_pkg::T_MERGE: if (commit) begin
				state_nxt = lpe_pkg::T_IDLE;
			end
			default: state_nxt = lpe_pkg::T_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_stall    = (state_q != lpe_pkg::T_IDLE);
		merge_start = (state_q == lpe_pkg::T_NORM) && lanes_done;
		commit      = (state_q == lpe_pkg::T_MERGE) && merge_ready &&
			(!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpe_pkg::T_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= in_xfer;
		end
	end

	// Channel lanes; channels without a sample input read zero
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		if (ch < lpe_pkg::HW_CHANNELS) begin : g_hw
			localparam int LO = (ch % 4) * SAMPLE_BITS;
			lpe_lane #(
				.SAMPLE_BITS (SAMPLE_BITS)
			) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.start   (start_q),
				.sample  (samp_q[ch]),
				.cal_min ((ch < 4) ? min_lo_q[LO +: SAMPLE_BITS] : min_hi_q[LO +: SAMPLE_BITS]),
				.cal_max ((ch < 4) ? max_lo_q[LO +: SAMPLE_BITS] : max_hi_q[LO +: SAMPLE_BITS]),
				.done    (lane_done[ch]),
				.norm    (lane_norm[ch])
			);
		end else begin : g_none
			assign lane_done[ch] = 1'b1;
			assign lane_norm[ch] = '0;
		end
	end

	assign lanes_done = &lane_done;

	lpe_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (merge_start),
		.norm         (lane_norm),
		.on_thr       (on_thr_q),
		.bin_thr      (bin_thr_q),
		.filter_reset (freset_q),
		.commit       (commit),
		.ready        (merge_ready),
		.res          (merge_res)
	);

	// Output register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= merge_res;
		end
	end

	assign out_valid         = out_valid_q;
	assign filtered_position = res_q.filtered_position;
	assign raw_position      = res_q.raw_position;
	assign line_seen         = res_q.line_seen;
	assign on_line           = res_q.on_line;
	assign binary_position   = res_q.binary_position;

	// A transferred scan moves the sequencer into normalisation
	a_in_to_norm: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == lpe_pkg::T_NORM)
		else $error("scan transfer did not start normalisation");

	// A new result appears only from a finished merge
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(merge_ready))
		else $error("result without a finished merge");

	// All lanes finish in the same cycle
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> lanes_done)
		else $error("channel lanes out of step");

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !commit)
		else $error("waiting result overwritten");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for line_position_estimator: drives scans, checks every result.
// Expected results come from a scoreboard class that predicts the block's behaviour.
// Depends on rtl/lpe_pkg.sv and the RTL of line_position_estimator.
`timescale 1ns / 1ps

module tb_top;

	localparam int SMP_W       = 10;
	localparam int CAL_W       = 4 * SMP_W;
	localparam int STALL_LIMIT = 5000;
	localparam int SEG_ITEMS   = 275;

	typedef struct packed {
		logic                  filter_reset;
		logic [7:0][SMP_W-1:0] smp;
	} scan_t;

	// Predicts the block's results and checks them in order
	class position_scoreboard;
		logic [CAL_W-1:0]              min_lo, min_hi, max_lo, max_hi;
		logic [lpe_pkg::THR_W-1:0]     on_thr, bin_thr;
		logic [lpe_pkg::POS_W-1:0]     hist [3];
		int unsigned                   slot;
		logic [lpe_pkg::POS_W-1:0]     held, last_raw;
		lpe_pkg::merge_res_t           pending [$];
		int                            errors;
		int                            checked;

		function new();
			min_lo  = '0;
			min_hi  = '0;
			max_lo  = {4{10'd1}};
			max_hi  = {4{10'd1}};
			on_thr  = 10'd500;
			bin_thr = 10'd500;
			foreach (hist[k])
				hist[k] = '0;
			slot     = 0;
			held     = '0;
			last_raw = '0;
			errors   = 0;
			checked  = 0;
		endfunction

		function void set_register(logic [lpe_pkg::CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
			case (idx)
				lpe_pkg::CFG_MIN_LO:  min_lo  = data;
				lpe_pkg::CFG_MIN_HI:  min_hi  = data;
				lpe_pkg::CFG_MAX_LO:  max_lo  = data;
				lpe_pkg::CFG_MAX_HI:  max_hi  = data;
				lpe_pkg::CFG_ON_THR:  on_thr  = data[lpe_pkg::THR_W-1:0];
				lpe_pkg::CFG_BIN_THR: bin_thr = data[lpe_pkg::THR_W-1:0];
				default: ;
			endcase
		endfunction

		// Scale one sample to 0..1000 against its calibration, clamped
		function int unsigned channel_level(int unsigned s, int unsigned mn, int unsigned mx);
			int unsigned v;
			if (mx <= mn)
				mx = mn + 1;
			if (s <= mn)
				return 0;
			v = ((s - mn) * 1000) / (mx - mn);
			return (v > 1000) ? 1000 : v;
		endfunction

		function logic [lpe_pkg::POS_W-1:0] middle_of(logic [lpe_pkg::POS_W-1:0] a,
				logic [lpe_pkg::POS_W-1:0] b, logic [lpe_pkg::POS_W-1:0] c);
			logic [lpe_pkg::POS_W-1:0] lo, hi;
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			if (c < lo)
				return lo;
			if (c > hi)
				return hi;
			return c;
		endfunction

		// Advance the filter state for one accepted scan and queue its result
		function void note_scan(scan_t s);
			int unsigned lvl, sum, wsum, bsum, bwsum, peak, mn, mx, binpos;
			lpe_pkg::merge_res_t want;
			sum = 0; wsum = 0; bsum = 0; bwsum = 0; peak = 0;
			if (s.filter_reset) begin
				foreach (hist[k])
					hist[k] = last_raw;
				held = last_raw;
			end
			for (int i = 0; i < 8; i++) begin
				mn = (i < 4) ? min_lo[i*SMP_W +: SMP_W] : min_hi[(i-4)*SMP_W +: SMP_W];
				mx = (i < 4) ? max_lo[i*SMP_W +: SMP_W] : max_hi[(i-4)*SMP_W +: SMP_W];
				lvl = channel_level(s.smp[i], mn, mx);
				sum  += lvl;
				wsum += lvl * (i * 1000);
				if (lvl > peak)
					peak = lvl;
				if (lvl > bin_thr) begin
					bsum  += lvl;
					bwsum += lvl * (i * 1000);
				end
			end
			if (sum != 0) begin
				last_raw   = lpe_pkg::POS_W'(wsum / sum);
				hist[slot] = last_raw;
				slot       = (slot == 2) ? 0 : slot + 1;
				held       = middle_of(hist[0], hist[1], hist[2]);
			end
			binpos = (bsum != 0) ? bwsum / bsum : held;
			want.filtered_position = held;
			want.raw_position      = last_raw;
			want.line_seen         = (sum != 0);
			want.on_line           = (peak > on_thr);
			want.binary_position   = lpe_pkg::POS_W'(binpos);
			pending.push_back(want);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			$display("MISMATCH result %0d %s: got %0d, expected %0d", checked, what, got, want);
			errors++;
		endtask

		task check_result(lpe_pkg::merge_res_t got);
			lpe_pkg::merge_res_t want;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result, filtered_position", got.filtered_position, 0);
				return;
			end
			want = pending.pop_front();
			if (got.filtered_position != want.filtered_position)
				report("filtered_position", got.filtered_position, want.filtered_position);
			if (got.raw_position != want.raw_position)
				report("raw_position", got.raw_position, want.raw_position);
			if (got.line_seen != want.line_seen)
				report("line_seen", got.line_seen, want.line_seen);
			if (got.on_line != want.on_line)
				report("on_line", got.on_line, want.on_line);
			if (got.binary_position != want.binary_position)
				report("binary_position", got.binary_position, want.binary_position);
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	scan_t                         scan_in;
	logic                          out_valid;
	logic                          out_stall;
	logic [lpe_pkg::POS_W-1:0]     filtered_position;
	logic [lpe_pkg::POS_W-1:0]     raw_position;
	logic                          line_seen;
	logic                          on_line;
	logic [lpe_pkg::POS_W-1:0]     binary_position;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [lpe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0]              cfg_data;

	position_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int cal_lo [8];
	int cal_hi [8];

	line_position_estimator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sample_0          (scan_in.smp[0]),
		.sample_1          (scan_in.smp[1]),
		.sample_2          (scan_in.smp[2]),
		.sample_3          (scan_in.smp[3]),
		.sample_4          (scan_in.smp[4]),
		.sample_5          (scan_in.smp[5]),
		.sample_6          (scan_in.smp[6]),
		.sample_7          (scan_in.smp[7]),
		.filter_reset      (scan_in.filter_reset),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.filtered_position (filtered_position),
		.raw_position      (raw_position),
		.line_seen         (line_seen),
		.on_line           (on_line),
		.binary_position   (binary_position),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the result channel at random, changed on the falling edge
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Check each result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(lpe_pkg::merge_res_t'({filtered_position, raw_position,
				line_seen, on_line, binary_position}));
	end

	// End the run when no transfer of any kind happens for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("line_position_estimator regression: fail");
		$finish;
	end

	// Offer one scan, with random idle cycles first; return on the falling edge after transfer
	task automatic send_scan(input scan_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		scan_in  <= s;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_scan(s);
		@(negedge clk);
	endtask

	// Hold the input until every expected result has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [lpe_pkg::CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	// Drain the block, then write the calibration registers from the shadows and the thresholds from the arguments
	task automatic program_calibration(input int on_thr, input int bin_thr);
		logic [CAL_W-1:0] mn_lo, mn_hi, mx_lo, mx_hi;
		for (int i = 0; i < 4; i++) begin
			mn_lo[i*SMP_W +: SMP_W] = SMP_W'(cal_lo[i]);
			mn_hi[i*SMP_W +: SMP_W] = SMP_W'(cal_lo[i+4]);
			mx_lo[i*SMP_W +: SMP_W] = SMP_W'(cal_hi[i]);
			mx_hi[i*SMP_W +: SMP_W] = SMP_W'(cal_hi[i+4]);
		end
		drain();
		write_reg(lpe_pkg::CFG_MIN_LO, mn_lo);
		write_reg(lpe_pkg::CFG_MIN_HI, mn_hi);
		write_reg(lpe_pkg::CFG_MAX_LO, mx_lo);
		write_reg(lpe_pkg::CFG_MAX_HI, mx_hi);
		write_reg(lpe_pkg::CFG_ON_THR, CAL_W'(on_thr));
		write_reg(lpe_pkg::CFG_BIN_THR, CAL_W'(bin_thr));
		cfg_valid <= 1'b0;
	endtask

	// Pick a calibration style for one random segment
	task automatic choose_calibration(input int style);
		int lo, hi;
		for (int i = 0; i < 8; i++) begin
			case (style)
				1: begin
					cal_lo[i] = 0;
					cal_hi[i] = 1023;
				end
				2: begin
					cal_lo[i] = $urandom_range(0, 1023);
					cal_hi[i] = $urandom_range(0, 1023);
				end
				4: begin
					// mix full span, inverted, equal and reset-like channels
					case ($urandom_range(0, 3))
						0: begin lo = 0; hi = 1023; end
						1: begin lo = 1023; hi = 0; end
						2: begin lo = $urandom_range(0, 1023); hi = lo; end
						default: begin lo = 0; hi = 1; end
					endcase
					cal_lo[i] = lo;
					cal_hi[i] = hi;
				end
				default: begin
					cal_lo[i] = $urandom_range(20, 200);
					cal_hi[i] = $urandom_range(700, 1023);
				end
			endcase
		end
		case (style)
			0: program_calibration($urandom_range(200, 800), $urandom_range(200, 800));
			1: program_calibration(0, 0);
			3: program_calibration(1000, 1023);
			4: program_calibration(1, 999);
			default: program_calibration($urandom_range(0, 1023), $urandom_range(0, 1023));
		endcase
	endtask

	// Build one random scan: mostly a plausible line under the current calibration
	function automatic scan_t make_scan();
		scan_t s;
		int pick, centre, spread, gap, lvl, raw;
		pick   = $urandom_range(0, 99);
		centre = $urandom_range(0, 7000);
		spread = $urandom_range(400, 2500);
		for (int i = 0; i < 8; i++) begin
			if (pick < 65) begin
				gap = (i * 1000 > centre) ? i * 1000 - centre : centre - i * 1000;
				lvl = (gap < spread) ? 1000 - gap * 1000 / spread : 0;
				raw = cal_lo[i] + ((cal_hi[i] - cal_lo[i]) * lvl) / 1000
					+ int'($urandom_range(0, 40)) - 20;
			end else if (pick < 80)
				raw = $urandom_range(0, 1023);
			else if (pick < 90)
				raw = $urandom_range(0, (cal_lo[i] > 1023) ? 1023 : cal_lo[i]);
			else
				raw = $urandom_range(0, 1) ? 1023 : 0;
			if (raw < 0)
				raw = 0;
			if (raw > 1023)
				raw = 1023;
			s.smp[i] = SMP_W'(raw);
		end
		s.filter_reset = ($urandom_range(0, 99) < 6);
		return s;
	endfunction

	initial begin
		scan_t s;
		sb             = new();
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		scan_in        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = lpe_pkg::CFG_MIN_LO;
		cfg_data       = '0;
		send_idle_pct  = 9;
		recv_stall_pct = 75;
		for (int i = 0; i < 8; i++) begin
			cal_lo[i] = 0;
			cal_hi[i] = 1;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset calibration: any nonzero sample reads full scale
		s = '0;
		send_scan(s);
		s.smp[7] = 10'h3FF;
		send_scan(s);
		s = '0;
		s.smp[0] = 10'd1;
		send_scan(s);
		s.smp = {8{10'h3FF}};
		send_scan(s);
		s = '0;
		s.filter_reset = 1'b1;
		send_scan(s);

		// Typical calibration, channel 3 with max equal to min and channel 5 with max below min
		for (int i = 0; i < 8; i++) begin
			cal_lo[i] = 60 + 10 * i;
			cal_hi[i] = 940 - 5 * i;
		end
		cal_hi[3] = cal_lo[3];
		cal_hi[5] = cal_lo[5] - 100;
		program_calibration(500, 500);
		s = '0;
		send_scan(s);
		s.smp = {8{10'h3FF}};
		send_scan(s);
		for (int i = 0; i < 8; i++)
			s.smp[i] = SMP_W'(cal_hi[i]);
		send_scan(s);
		for (int i = 0; i < 8; i++)
			s.smp[i] = SMP_W'(cal_lo[i]);
		send_scan(s);
		s = '0;
		s.smp[0] = SMP_W'(cal_hi[0]);
		s.smp[1] = SMP_W'((cal_lo[1] + cal_hi[1]) / 2);
		send_scan(s);
		s = '0;
		s.smp[7] = SMP_W'(cal_hi[7]);
		s.smp[6] = SMP_W'((cal_lo[6] + cal_hi[6]) / 2);
		send_scan(s);
		s = '0;
		s.smp[3] = SMP_W'(cal_hi[3] + 1);
		s.smp[4] = SMP_W'(cal_hi[4]);
		s.filter_reset = 1'b1;
		send_scan(s);
		s = '0;
		s.filter_reset = 1'b1;
		send_scan(s);
		s = '0;
		s.smp[2] = SMP_W'(cal_lo[2] + (cal_hi[2] - cal_lo[2]) / 5);
		send_scan(s);
		s = '0;
		s.smp[3] = SMP_W'(cal_lo[3] + 1);
		send_scan(s);
		s = '0;
		s.smp[5] = SMP_W'(cal_lo[5] + 1);
		send_scan(s);

		// Threshold extremes
		program_calibration(0, 1023);
		s = '0;
		s.smp[4] = SMP_W'(cal_hi[4]);
		s.smp[5] = SMP_W'(cal_lo[5] + 1);
		send_scan(s);
		s = '0;
		s.smp[1] = SMP_W'(cal_lo[1] + 1);
		send_scan(s);

		// Random segments: two idling modes, then none
		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				send_idle_pct  = 75;
				recv_stall_pct = 9;
			end else if (seg == 4) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			choose_calibration(seg);
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (seg == 1 && n == 137)
					drain();
				send_scan(make_scan());
			end
		end

		drain();
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("line_position_estimator regression: pass");
		else
			$display("line_position_estimator regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/lpe_pkg.sv
rtl/lpe_div.sv
rtl/lpe_lane.sv
rtl/lpe_merge.sv
rtl/line_position_estimator.sv
sim/tb_top.sv
